@@ rtl/stis_pkg.sv @@
// Shared constants and codes of the sorted table interval search unit.
`default_nettype none

package stis_pkg;

  // Fixed field widths
  localparam int KEY_W = 32;
  localparam int IDX_W = 10;
  localparam int CFG_W = 11;
  localparam int BIN_W = 11;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Register reset and the below-first-entry result
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam logic [BIN_W-1:0] BIN_BELOW = '1;

endpackage

`default_nettype wire

@@ rtl/sorted_table_interval_search_unit.sv @@
// Operation: a query reads entry 0, then bisects over the n entries in use with one table read per
// step, and a key below entry 0 ends the search after that first read; a write gives no result.
// Throughput: one query at a time, bounded by one table read per bisection step on the single
// synchronous read port; the next beat is taken while a finished result waits at the output.
// Reset: control state clears asynchronously, entries_in_use returns to 1024; table contents
// are undefined until written.
`default_nettype none

module sorted_table_interval_search_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // configuration
  input  wire                                 cfg_we_i,
  input  wire  [stis_pkg::CFG_W-1:0]          cfg_wdata_i,
  // request channel
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  wire                                 req_type_i,
  input  wire  [stis_pkg::IDX_W-1:0]          entry_index_i,
  input  wire  signed [stis_pkg::KEY_W-1:0]   key_value_i,
  // result channel
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic signed [stis_pkg::BIN_W-1:0]   bin_index_o
);

  import stis_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_STEP  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CFG_W-1:0]        cfg_q;
  logic [VALUE_WIDTH-1:0]  key_q, key_d;
  logic [NW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [BIN_W-1:0]        res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  logic [BIN_W-1:0]        out_bin_q, out_bin_d;

  // Table storage
  logic [VALUE_WIDTH-1:0]  mem_q [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0]  rd_data_q;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  logic [VALUE_WIDTH-1:0]  key_ext;
  logic                    in_beat;
  logic [31:0]             cfg_ext, n_used;
  logic                    le;
  logic [NW-1:0]           lo_n, hi_n, mid_n, span_n;
  logic [NW:0]             sum_n, sum_0;

  // Key taken to the stored value width
  if (VALUE_WIDTH <= KEY_W) begin : g_key_trunc
    assign key_ext = key_value_i[VALUE_WIDTH-1:0];
  end else begin : g_key_ext
    assign key_ext = {{(VALUE_WIDTH-KEY_W){1'b0}}, key_value_i};
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_beat     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_bin_q;

  // Entries in use, clamped to [2, TABLE_DEPTH]
  assign cfg_ext = 32'(cfg_q);
  always_comb begin
    if (cfg_ext < 32'd2) begin
      n_used = 32'd2;
    end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
      n_used = 32'(TABLE_DEPTH);
    end else begin
      n_used = cfg_ext;
    end
  end

  // First midpoint after the entry-0 check: lo = 0, hi = n
  assign sum_0 = {1'b0, hi_q} + {1'b0, lo_q};

  // One bisection step on the entry just read
  assign le     = $signed(rd_data_q) <= $signed(key_q);
  assign lo_n   = le ? mid_q : lo_q;
  assign hi_n   = le ? hi_q : mid_q;
  assign sum_n  = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n  = sum_n[NW:1];
  assign span_n = hi_n - lo_n;

  // Write port decode: positions past the table are dropped
  assign wr_en   = in_beat && (req_type_i == REQ_WRITE) &&
                   (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index_i);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_bin_d   = out_bin_q;
    rd_en       = 1'b0;
    rd_addr     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_beat && (req_type_i == REQ_QUERY)) begin
          key_d   = key_ext;
          lo_d    = '0;
          hi_d    = NW'(n_used);
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        // entry 0 in rd_data_q; n >= 2 so at least one step follows unless the key lies below entry 0
        if ($signed(rd_data_q) > $signed(key_q)) begin
          res_d   = BIN_BELOW;
          state_d = S_DONE;
        end else begin
          mid_d   = sum_0[NW:1];
          rd_en   = 1'b1;
          rd_addr = sum_0[AW:1];
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (span_n > NW'(1)) begin
          mid_d   = mid_n;
          rd_en   = 1'b1;
          rd_addr = mid_n[AW-1:0];
        end else begin
          res_d   = BIN_W'(lo_n);
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free or draining
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_bin_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    res_q     <= res_d;
    out_bin_q <= out_bin_d;
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= key_ext;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/stis_checker.sv @@
// Port-level checks for the sorted table interval search unit, bound to the top level.
`default_nettype none

module stis_assert (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_valid_i,
  input wire                         in_ready_o,
  input wire                         req_type_i,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire [stis_pkg::BIN_W-1:0]   bin_index_o
);

  import stis_pkg::*;

  // A stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_index_o))
    else $error("result beat dropped or changed while stalled");

  // A write beat never makes a result appear
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_WRITE) && !out_valid_o |=> !out_valid_o)
    else $error("write beat produced a result");

  // A query beat makes the block busy on the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == REQ_QUERY) |=> !in_ready_o)
    else $error("query beat did not start a search");

  // Busy only ever starts from an accepted query
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && (req_type_i == REQ_QUERY)))
    else $error("block went busy without a query beat");

  // A new result only follows a busy stretch
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a search");

endmodule

bind sorted_table_interval_search_unit stis_assert u_stis_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .bin_index_o (bin_index_o)
);

`default_nettype wire
